// File: rtl/ppv_pkg.sv
`default_nettype none

package ppv_pkg;

    // width of the register interface
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // unsigned scale registers are Q15.16 without a sign bit
    localparam int SCALE_W = 31;
    localparam int NEAR_W  = 32;

    // partial product chunk taken from the wide multiplier operand
    localparam int CHUNK_W = 32;

    localparam logic [SCALE_W-1:0] ASPECT_RESET = 31'd65536;
    localparam logic [SCALE_W-1:0] FOCAL_RESET  = 31'd65536;
    localparam logic [SCALE_W-1:0] DSCALE_RESET = 31'd65536;
    localparam logic [NEAR_W-1:0]  NEAR_RESET   = 32'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ASPECT = 2'd0,
        REG_FOCAL  = 2'd1,
        REG_DSCALE = 2'd2,
        REG_NEAR   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic sx_neg;
        logic sy_neg;
        logic d_neg;
        logic zero;
    } flag_t;

endpackage

`default_nettype wire

// File: rtl/perspective_vertex_project_core.sv
`default_nettype none

// perspective projection of a stream of 3-D vertices
// input stream s_axis: one vertex per transaction, x, y, z signed fixed point
// output stream m_axis: screen x, screen y, depth in tdata, zero-depth flag in tuser
// screen_x = aspect*focal*x/z, screen_y = focal*y/z, depth = dscale*(z - near),
// each truncated toward zero and saturated; z of zero divides by one instead
// config port: cfg_we, cfg_index, cfg_data write aspect, focal, depth scale and
// near plane; write only while no vertex is in flight
// throughput: one vertex per clock while the skid entry is empty
// the bit-per-stage divider sets the depth of the pipeline
// the pipeline is input register, magnitude stage, two 2-stage multipliers,
// then the divider with one overflow stage and one stage per quotient bit
// a 2-entry output register/skid pair absorbs a stalled receiver; the whole
// pipeline halts only when both entries are full
// reset clears all valid bits and loads the register defaults
module perspective_vertex_project_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [ppv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ppv_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // vertex_x, vertex_y, vertex_z, zero pad
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // screen_x, screen_y, depth_out, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // zero_depth
    output logic [0:0]                                 m_axis_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int TDW    = ((3*W+7)/8)*8;
    localparam int SW     = ppv_pkg::SCALE_W;
    localparam int DSW    = ((W > ppv_pkg::NEAR_W) ? W : ppv_pkg::NEAR_W) + 1;
    localparam int PXW    = W + SW;
    localparam int MXW    = PXW + SW;
    localparam int PYW    = W + SW;
    localparam int PDW    = DSW + SW;
    localparam int MDW    = PDW - F;
    localparam int NST    = W + 7;
    localparam int RW     = 3*W + 1;

    localparam logic [W-1:0] ONE_F   = {{(W-1){1'b0}}, 1'b1} << F;
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};

    function automatic logic [W-1:0] sat_coord(
        input logic         big,
        input logic [W-1:0] mag,
        input logic         neg
    );
        logic [W-1:0] r;
        if (neg)
        begin
            r = (big || mag > SAT_MIN) ? SAT_MIN : -mag;
        end
        else
        begin
            r = (big || mag > SAT_MAX) ? SAT_MAX : mag;
        end
        return r;
    endfunction

    // configuration registers
    logic [SW-1:0]              aspect_reg;
    logic [SW-1:0]              focal_reg;
    logic [SW-1:0]              dscale_reg;
    logic [ppv_pkg::NEAR_W-1:0] near_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aspect_reg <= ppv_pkg::ASPECT_RESET;
            focal_reg  <= ppv_pkg::FOCAL_RESET;
            dscale_reg <= ppv_pkg::DSCALE_RESET;
            near_reg   <= ppv_pkg::NEAR_RESET;
        end
        else if (cfg_we)
        begin
            case (ppv_pkg::cfg_reg_t'(cfg_index))
                ppv_pkg::REG_ASPECT: aspect_reg <= cfg_data[SW-1:0];
                ppv_pkg::REG_FOCAL:  focal_reg  <= cfg_data[SW-1:0];
                ppv_pkg::REG_DSCALE: dscale_reg <= cfg_data[SW-1:0];
                ppv_pkg::REG_NEAR:   near_reg   <= cfg_data[ppv_pkg::NEAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    logic           en;
    logic [NST-1:0] v_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    logic [RW-1:0]  out_data_reg;
    logic [RW-1:0]  out_data_next;
    logic [RW-1:0]  skid_data_reg;
    logic [RW-1:0]  skid_data_next;
    logic [RW-1:0]  res;

    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], s_axis_tvalid};
        end
    end

    // stage 0: input register
    logic [W-1:0] x_reg;
    logic [W-1:0] y_reg;
    logic [W-1:0] z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= s_axis_tdata[W-1:0];
            y_reg <= s_axis_tdata[2*W-1:W];
            z_reg <= s_axis_tdata[3*W-1:2*W];
        end
    end

    // stage 1: magnitudes, signs, z - near
    logic [W-1:0]   xm;
    logic [W-1:0]   ym;
    logic [W-1:0]   zm;
    logic           zero;
    logic [DSW-1:0] d;
    logic [DSW-1:0] dm;
    ppv_pkg::flag_t flag;

    always_comb
    begin
        zero = (z_reg == '0);
        xm   = x_reg[W-1] ? -x_reg : x_reg;
        ym   = y_reg[W-1] ? -y_reg : y_reg;
        // z of zero divides by one, which gives the plain shifted product
        zm   = zero ? ONE_F : (z_reg[W-1] ? -z_reg : z_reg);
        d    = {{(DSW-W){z_reg[W-1]}}, z_reg}
             - {{(DSW-ppv_pkg::NEAR_W){near_reg[ppv_pkg::NEAR_W-1]}}, near_reg};
        dm   = d[DSW-1] ? -d : d;
        flag.sx_neg = x_reg[W-1] ^ z_reg[W-1];
        flag.sy_neg = y_reg[W-1] ^ z_reg[W-1];
        flag.d_neg  = d[DSW-1];
        flag.zero   = zero;
    end

    logic [W-1:0]   xm_reg;
    logic [W-1:0]   ym_reg;
    logic [DSW-1:0] dm_reg;
    logic [W-1:0]   zm_reg   [1:5];
    ppv_pkg::flag_t flag_reg [1:NST-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm_reg      <= xm;
            ym_reg      <= ym;
            dm_reg      <= dm;
            zm_reg[1]   <= zm;
            flag_reg[1] <= flag;
            for (int i = 2; i <= 5; i++)
            begin
                zm_reg[i] <= zm_reg[i-1];
            end
            for (int i = 2; i < NST; i++)
            begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    // stages 2-3: first products
    logic [PXW-1:0] px_p;
    logic [PYW-1:0] py_p;
    logic [PDW-1:0] pd_p;

    ppv_mul #(.AW(W), .BW(SW)) u_mul_x (
        .clk (clk),
        .en  (en),
        .a   (xm_reg),
        .b   (aspect_reg),
        .p   (px_p)
    );

    ppv_mul #(.AW(W), .BW(SW)) u_mul_y (
        .clk (clk),
        .en  (en),
        .a   (ym_reg),
        .b   (focal_reg),
        .p   (py_p)
    );

    ppv_mul #(.AW(DSW), .BW(SW)) u_mul_d (
        .clk (clk),
        .en  (en),
        .a   (dm_reg),
        .b   (dscale_reg),
        .p   (pd_p)
    );

    // stages 4-5: x times focal; y product and depth ride alongside
    logic [MXW-1:0] mx_p;
    logic [MDW-1:0] md;
    logic [W-1:0]   dep;
    logic [PYW-1:0] py_reg  [4:5];
    logic [W-1:0]   dep_reg [4:NST-1];

    ppv_mul #(.AW(PXW), .BW(SW)) u_mul_xf (
        .clk (clk),
        .en  (en),
        .a   (px_p),
        .b   (focal_reg),
        .p   (mx_p)
    );

    assign md  = pd_p[PDW-1:F];
    assign dep = sat_coord(|md[MDW-1:W], md[W-1:0], flag_reg[3].d_neg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_reg[4]  <= py_p;
            py_reg[5]  <= py_reg[4];
            dep_reg[4] <= dep;
            for (int i = 5; i < NST; i++)
            begin
                dep_reg[i] <= dep_reg[i-1];
            end
        end
    end

    // stages 6 to NST-1: dividers
    logic [W-1:0] qx;
    logic [W-1:0] qy;
    logic         ovf_x;
    logic         ovf_y;

    ppv_div #(.NW(MXW), .DVW(W + F), .QW(W)) u_div_x (
        .clk      (clk),
        .en       (en),
        .dividend (mx_p),
        .divisor  ({zm_reg[5], {F{1'b0}}}),
        .q        (qx),
        .ovf      (ovf_x)
    );

    ppv_div #(.NW(PYW), .DVW(W), .QW(W)) u_div_y (
        .clk      (clk),
        .en       (en),
        .dividend (py_reg[5]),
        .divisor  (zm_reg[5]),
        .q        (qy),
        .ovf      (ovf_y)
    );

    assign res = {flag_reg[NST-1].zero,
                  dep_reg[NST-1],
                  sat_coord(ovf_y, qy, flag_reg[NST-1].sy_neg),
                  sat_coord(ovf_x, qx, flag_reg[NST-1].sx_neg)};

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_next = v_reg[NST-1];
            out_data_next  = res;
        end
        else if (v_reg[NST-1])
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = TDW'(out_data_reg[3*W-1:0]);
    assign m_axis_tuser[0] = out_data_reg[3*W];

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST-1] && skid_valid_reg |=> v_reg[NST-1])
        else $error("last pipeline stage lost a transaction during a stall");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready && v_reg[NST-1] && !skid_valid_reg
        |=> skid_valid_reg)
        else $error("blocked result did not move into the skid entry");
`endif

endmodule

`default_nettype wire

// File: rtl/ppv_mul.sv
`default_nettype none

// two-stage unsigned multiplier: 32-bit chunks of a times b, then the sum
module ppv_mul #(
    parameter int AW = 32,
    parameter int BW = 31
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    output logic [AW+BW-1:0]   p
);

    localparam int NCH = (AW + ppv_pkg::CHUNK_W - 1) / ppv_pkg::CHUNK_W;
    localparam int PW  = AW + BW;
    localparam int XW  = NCH * ppv_pkg::CHUNK_W;
    localparam int CPW = ppv_pkg::CHUNK_W + BW;

    logic [XW-1:0]  a_ext;
    logic [CPW-1:0] pp_reg [0:NCH-1];
    logic [PW-1:0]  p_next;
    logic [PW-1:0]  p_reg;

    assign a_ext = XW'(a);

    for (genvar k = 0; k < NCH; k++) begin : g_chunk
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_reg[k] <= CPW'(a_ext[k*ppv_pkg::CHUNK_W +: ppv_pkg::CHUNK_W]) * CPW'(b);
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int k = 0; k < NCH; k++)
        begin
            p_next = p_next + (PW'(pp_reg[k]) << (ppv_pkg::CHUNK_W * k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: rtl/ppv_div.sv
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
// ovf is set when the quotient does not fit in QW bits
module ppv_div #(
    parameter int NW  = 94,
    parameter int DVW = 48,
    parameter int QW  = 32
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [NW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic [QW-1:0]       q,
    output logic                ovf
);

    localparam int TW = NW - QW;
    localparam int CW = ((TW > DVW) ? TW : DVW) + 1;

    logic [TW-1:0]  top_bits;
    logic           ovf0;

    logic [DVW-1:0] rem_reg [0:QW];
    logic [DVW-1:0] dvs_reg [0:QW];
    logic [QW-1:0]  lo_reg  [0:QW];
    logic [QW-1:0]  q_reg   [0:QW];
    logic           ovf_reg [0:QW];

    assign top_bits = dividend[NW-1:QW];
    assign ovf0     = CW'(top_bits) >= CW'(divisor);

    // upper part of the dividend must stay below the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DVW'(top_bits);
            dvs_reg[0] <= divisor;
            lo_reg[0]  <= dividend[QW-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [DVW:0]  rs;
        logic [DVW:0]  diff;
        logic          ge;
        logic [QW-1:0] q_next;

        always_comb
        begin
            rs     = {rem_reg[k-1], lo_reg[k-1][QW-k]};
            diff   = rs - {1'b0, dvs_reg[k-1]};
            ge     = rs >= {1'b0, dvs_reg[k-1]};
            q_next = q_reg[k-1];
            q_next[QW-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DVW-1:0] : rs[DVW-1:0];
                dvs_reg[k] <= dvs_reg[k-1];
                lo_reg[k]  <= lo_reg[k-1];
                q_reg[k]   <= q_next;
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign q   = q_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire

// File: tb/perspective_vertex_project_checker.sv
`timescale 1ns / 1ps

module perspective_vertex_project_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ppv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ppv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    // vertex_x, vertex_y, vertex_z
    input  wire logic [95:0]                    s_axis_tdata,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // screen_x, screen_y, depth_out
    input  wire logic [95:0]                    m_axis_tdata,
    // zero_depth
    input  wire logic [0:0]                     m_axis_tuser,
    output int                                  mismatch_count,
    output int                                  outstanding
);

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam logic [127:0] POS_LIMIT = 128'h7FFF_FFFF;
    localparam logic [127:0] NEG_LIMIT = 128'h8000_0000;

    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic [COORD_W-1:0] depth;
        logic               zero_depth;
    } projection_t;

    logic [ppv_pkg::SCALE_W-1:0] aspect_q;
    logic [ppv_pkg::SCALE_W-1:0] focal_q;
    logic [ppv_pkg::SCALE_W-1:0] dscale_q;
    logic [ppv_pkg::NEAR_W-1:0]  near_q;
    projection_t                 projections_q[$];

    // magnitude plus sign back to a saturated two's complement coordinate
    function automatic logic [COORD_W-1:0] clamp(logic [127:0] mag, logic neg);
        if (neg)
            return (mag > NEG_LIMIT) ? NEG_LIMIT[COORD_W-1:0] : (~mag[COORD_W-1:0] + 1'b1);
        return (mag > POS_LIMIT) ? POS_LIMIT[COORD_W-1:0] : mag[COORD_W-1:0];
    endfunction

    function automatic projection_t project_vertex(logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y,
                                                   logic [COORD_W-1:0] z);
        logic [COORD_W-1:0] mag_x;
        logic [COORD_W-1:0] mag_y;
        logic [COORD_W-1:0] mag_z;
        logic [63:0]        diff;
        logic [63:0]        mag_d;
        logic [127:0]       prod_x;
        logic [127:0]       prod_y;
        logic [127:0]       scaled_d;
        projection_t        proj;
        mag_x = x[COORD_W-1] ? -x : x;
        mag_y = y[COORD_W-1] ? -y : y;
        mag_z = z[COORD_W-1] ? -z : z;
        // exact products, one truncation at the end
        prod_x = 128'(mag_x) * 128'(aspect_q) * 128'(focal_q);
        prod_y = 128'(mag_y) * 128'(focal_q);
        if (z == '0)
        begin
            prod_x = prod_x >> (2 * FRAC_BITS);
            prod_y = prod_y >> FRAC_BITS;
        end
        else
        begin
            prod_x = (prod_x / 128'(mag_z)) >> FRAC_BITS;
            prod_y = prod_y / 128'(mag_z);
        end
        // depth difference is taken at full width, no wrap at 32 bits
        diff     = {{32{z[COORD_W-1]}}, z} - {{32{near_q[ppv_pkg::NEAR_W-1]}}, near_q};
        mag_d    = diff[63] ? -diff : diff;
        scaled_d = (128'(mag_d) * 128'(dscale_q)) >> FRAC_BITS;
        proj.screen_x   = clamp(prod_x, x[COORD_W-1] ^ z[COORD_W-1]);
        proj.screen_y   = clamp(prod_y, y[COORD_W-1] ^ z[COORD_W-1]);
        proj.depth      = clamp(scaled_d, diff[63]);
        proj.zero_depth = (z == '0);
        return proj;
    endfunction

    task automatic report_mismatch(string field, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aspect_q       <= ppv_pkg::ASPECT_RESET;
            focal_q        <= ppv_pkg::FOCAL_RESET;
            dscale_q       <= ppv_pkg::DSCALE_RESET;
            near_q         <= ppv_pkg::NEAR_RESET;
            outstanding    <= 0;
            mismatch_count = 0;
            projections_q.delete();
        end
        else
        begin : monitor
            projection_t got;
            projection_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tuser[0]};
                if (projections_q.size() == 0)
                    report_mismatch("transaction with no vertex pending", got.screen_x, '0);
                else
                begin
                    want = projections_q.pop_front();
                    if (got.screen_x !== want.screen_x)
                        report_mismatch("screen_x", got.screen_x, want.screen_x);
                    if (got.screen_y !== want.screen_y)
                        report_mismatch("screen_y", got.screen_y, want.screen_y);
                    if (got.depth !== want.depth)
                        report_mismatch("depth_out", got.depth, want.depth);
                    if (got.zero_depth !== want.zero_depth)
                        report_mismatch("zero_depth", 32'(got.zero_depth),
                                        32'(want.zero_depth));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                projections_q.insert(projections_q.size(),
                                     project_vertex(s_axis_tdata[31:0],
                                                    s_axis_tdata[63:32],
                                                    s_axis_tdata[95:64]));
            if (cfg_we)
            begin
                case (ppv_pkg::cfg_reg_t'(cfg_index))
                    ppv_pkg::REG_ASPECT: aspect_q <= cfg_data[ppv_pkg::SCALE_W-1:0];
                    ppv_pkg::REG_FOCAL:  focal_q  <= cfg_data[ppv_pkg::SCALE_W-1:0];
                    ppv_pkg::REG_DSCALE: dscale_q <= cfg_data[ppv_pkg::SCALE_W-1:0];
                    ppv_pkg::REG_NEAR:   near_q   <= cfg_data[ppv_pkg::NEAR_W-1:0];
                    default:             ;
                endcase
            end
            outstanding <= projections_q.size();
        end
    end

endmodule

// File: tb/perspective_vertex_project_core_tb.sv
`timescale 1ns / 1ps

module perspective_vertex_project_core_tb;
    import ppv_pkg::*;

    localparam int COORD_W          = 32;
    localparam int FRAC_BITS        = 16;
    localparam int DATA_W           = ((3 * COORD_W + 7) / 8) * 8;
    localparam int PIPE_LATENCY     = COORD_W + 8;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_PHASES    = 7;
    localparam int PHASE_VERTICES   = 112;
    localparam int EXTREME_VERTICES = 60;

    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE       = 32'h0001_0000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    cfg_reg_t              cfg_index     = REG_ASPECT;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tready = 1'b0;
    wire logic             s_axis_tready;
    wire logic             m_axis_tvalid;
    wire logic [DATA_W-1:0] m_axis_tdata;
    wire logic [0:0]       m_axis_tuser;

    int   mismatch_count;
    int   outstanding;
    int   cycle_count    = 0;
    int   vertices_sent  = 0;
    int   zero_z_sent    = 0;
    int   settings_used  = 0;
    int   hold_reqs      = 0;
    int   hold_done      = 0;
    int   hold_left      = 0;
    int   run_left       = 0;
    logic run_ready      = 1'b1;
    logic no_gap         = 1'b0;

    perspective_vertex_project_core #(
        .COORD_WIDTH (COORD_W),
        .FRAC_BITS   (FRAC_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    perspective_vertex_project_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random runs of ready and stall, plus requested long hold-offs
    always @(posedge clk)
    begin : receiver
        int roll;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_done != hold_reqs) begin
            m_axis_tready <= 1'b0;
            hold_done     <= hold_done + 1;
            hold_left     <= HOLD_OFF_CYCLES - 1;
        end
        else if (run_left != 0) begin
            m_axis_tready <= run_ready;
            run_left      <= run_left - 1;
        end
        else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                run_ready     <= 1'b1;
                m_axis_tready <= 1'b1;
                run_left      <= $urandom_range(0, 39);
            end
            else begin
                run_ready     <= 1'b0;
                m_axis_tready <= 1'b0;
                if (roll < 90)
                    run_left <= $urandom_range(0, 2);
                else if (roll < 98)
                    run_left <= $urandom_range(3, 11);
                else
                    run_left <= $urandom_range(30, 80);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] random_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return $urandom;
        if (roll < 60)
            return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        if (roll < 75)
            return 32'($urandom_range(0, 32'h800_0000)) - 32'h400_0000;
        if (roll < 85) begin
            case ($urandom_range(0, 6))
                0:       return COORD_MIN;
                1:       return COORD_MAX;
                2:       return 32'h0;
                3:       return 32'h1;
                4:       return ALL_ONES;
                5:       return ONE;
                default: return -ONE;
            endcase
        end
        return 32'($urandom_range(0, 128)) - 32'd64;
    endfunction

    function automatic logic [31:0] random_depth();
        if ($urandom_range(0, 9) == 0)
            return 32'h0;
        return random_coord();
    endfunction

    function automatic logic [31:0] random_scale();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return $urandom_range(32'h4000, 32'h4_0000);
        if (roll < 60)
            return $urandom;
        if (roll < 75) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0;
                1:       return 32'h1;
                2:       return COORD_MAX;
                default: return ALL_ONES;
            endcase
        end
        return $urandom_range(0, 32'h1000);
    endfunction

    function automatic logic [31:0] random_near();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom_range(0, 32'h10_0000);
        if (roll < 70)
            return $urandom;
        if (roll < 85) begin
            case ($urandom_range(0, 3))
                0:       return COORD_MIN;
                1:       return COORD_MAX;
                2:       return 32'h0;
                default: return ALL_ONES;
            endcase
        end
        return 32'h0 - 32'($urandom_range(1, 32'h10_0000));
    endfunction

    // writes all four registers back to back; block must be idle
    task automatic program_regs(logic [31:0] aspect, logic [31:0] focal,
                                logic [31:0] dscale, logic [31:0] near);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ASPECT;
        cfg_data  <= aspect;
        @(posedge clk);
        cfg_index <= REG_FOCAL;
        cfg_data  <= focal;
        @(posedge clk);
        cfg_index <= REG_DSCALE;
        cfg_data  <= dscale;
        @(posedge clk);
        cfg_index <= REG_NEAR;
        cfg_data  <= near;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        vertices_sent++;
        if (z == 32'h0)
            zero_z_sent++;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic send_random_vertices(int count);
        repeat (count) send_vertex(random_coord(), random_coord(), random_depth());
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: signs, saturation, zero depth, depth on the near plane
        settings_used = 1;
        send_vertex(32'h0, 32'h0, 32'h0);
        send_vertex(ONE, ONE, ONE);
        send_vertex(ALL_ONES, 32'h1, 32'hFFFF_0000);
        send_vertex(COORD_MAX, COORD_MAX, 32'h1);
        send_vertex(COORD_MIN, COORD_MIN, 32'h1);
        send_vertex(COORD_MIN, COORD_MAX, ALL_ONES);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MIN);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
        send_vertex(32'h0003_0000, 32'hFFFE_0000, 32'h0004_0000);
        send_vertex(COORD_MAX, COORD_MIN, 32'h0);
        send_vertex(32'hFFFF_FFFB, 32'h7, 32'h0);
        send_vertex(ONE, ONE, 32'd6554);
        send_vertex(ONE, 32'hFFFF_0000, COORD_MIN);
        send_vertex(32'h0005_0000, 32'h0005_0000, 32'hFFFF_8000);
        wait_drained();

        // largest scales (top data bit dropped by the 31-bit registers), lowest near
        program_regs(ALL_ONES, ALL_ONES, ALL_ONES, COORD_MIN);
        send_vertex(ONE, ONE, ONE);
        send_vertex(COORD_MIN, COORD_MAX, 32'h0);
        send_vertex(32'h1, 32'h1, COORD_MAX);
        send_vertex(32'h0, 32'h0, 32'h0);
        send_random_vertices(EXTREME_VERTICES);

        program_regs(32'h0, 32'h0, 32'h0, COORD_MAX);
        send_random_vertices(EXTREME_VERTICES);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_regs(random_scale(), random_scale(), random_scale(), random_near());
            no_gap = (phase == 0) || (phase == 3);
            // sender keeps offering while the receiver holds off, so the pipe fills
            if (phase == 0)
                hold_reqs <= hold_reqs + 1;
            send_random_vertices(PHASE_VERTICES);
        end
        no_gap = 1'b0;

        repeat (PIPE_LATENCY + 10) @(posedge clk);
        $display("%0d vertices over %0d register settings, %0d of them at zero depth",
                 vertices_sent, settings_used, zero_z_sent);
        $display("%0d long receiver hold-off(s) with a full pipeline, %0d mismatches",
                 hold_done, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: perspective_vertex_project_core.f
rtl/ppv_pkg.sv
rtl/ppv_mul.sv
rtl/ppv_div.sv
rtl/perspective_vertex_project_core.sv
tb/perspective_vertex_project_checker.sv
tb/perspective_vertex_project_core_tb.sv
